// ===== rtl/tqls_pkg.sv =====
// Shared constants, types and tables for the Q-learning step core.
`timescale 1ns / 1ps

package tqls_pkg;

    // Table geometry
    localparam int ANGLE_BINS  = 16;
    localparam int OFFSET_BINS = 12;
    localparam int ACC_ACTIONS = 7;
    localparam int DIR_ACTIONS = 10;
    localparam int ACTIONS     = ACC_ACTIONS * DIR_ACTIONS;
    localparam int TABLE_DEPTH = ANGLE_BINS * OFFSET_BINS * ACTIONS;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int ACT_W       = $clog2(ACTIONS);

    // Field widths
    localparam int ANGLE_W  = 15;
    localparam int OFFSET_W = 16;
    localparam int VALUE_W  = 32;
    localparam int FRAC_W   = 16;
    localparam int BIN_W    = 4;
    localparam int ACC_W    = 3;
    localparam int DIR_W    = 4;

    // Offset compare is done on offset*OFFSET_BINS
    localparam int OFF_CMP_W = 24;

    // Register map
    localparam int CFG_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;
    localparam logic [REG_IDX_W-1:0] REG_LEARN_RATE      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DISCOUNT_FACTOR = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_EXPLORE_CHANCE  = 2'd2;

    localparam logic [FRAC_W-1:0] LEARN_RATE_RST      = 16'd3277;
    localparam logic [FRAC_W-1:0] DISCOUNT_FACTOR_RST = 16'd22938;
    localparam logic [FRAC_W-1:0] EXPLORE_CHANCE_RST  = 16'd3277;

    // Angle thresholds -pi + i*pi/8 in Q3.12, rounded so that x < T is exact
    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT [ANGLE_BINS] = '{
        -15'sd12867, -15'sd11259, -15'sd9650, -15'sd8042,
        -15'sd6433,  -15'sd4825,  -15'sd3216, -15'sd1608,
        15'sd0,      15'sd1609,   15'sd3217,  15'sd4826,
        15'sd6434,   15'sd8043,   15'sd9651,  15'sd11260
    };

    // Offset threshold i scaled by OFFSET_BINS: -6 m + i*12 m/OFFSET_BINS (Q8.8)
    function automatic logic signed [OFF_CMP_W-1:0] offset_limit(input int idx);
        return OFF_CMP_W'(-1536 * OFFSET_BINS + 3072 * idx);
    endfunction

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_SEED,
        ST_SCAN,
        ST_DRAIN,
        ST_MUL1,
        ST_SUM,
        ST_MUL2,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/tqls_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tqls_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/tqls_quant.sv =====
// Heading angle and lateral offset quantizer.
`timescale 1ns / 1ps

module tqls_quant
    import tqls_pkg::*;
(
    input  logic signed [ANGLE_W-1:0]  heading_angle,
    input  logic signed [OFFSET_W-1:0] lateral_offset,
    output logic [BIN_W-1:0]           angle_bin,
    output logic [BIN_W-1:0]           offset_bin
);

    localparam logic signed [OFF_CMP_W-1:0] OFF_SCALE = OFF_CMP_W'(OFFSET_BINS);

    logic signed [OFF_CMP_W-1:0] off_scaled;

    assign off_scaled = OFF_CMP_W'(lateral_offset) * OFF_SCALE;

    // lowest-index threshold above the input wins; none above -> bin 0
    always_comb
    begin
        angle_bin = '0;
        for (int i = ANGLE_BINS - 1; i >= 0; i--)
        begin
            if (heading_angle < ANGLE_LIMIT[i])
            begin
                angle_bin = BIN_W'(i);
            end
        end
    end

    always_comb
    begin
        offset_bin = '0;
        for (int i = OFFSET_BINS - 1; i >= 0; i--)
        begin
            if (off_scaled < offset_limit(i))
            begin
                offset_bin = BIN_W'(i);
            end
        end
    end

endmodule

// ===== rtl/tabular_q_learning_step_core.sv =====
// Top level: tabular Q-learning decision step with table in on-chip RAM.
`timescale 1ns / 1ps

//  Channel   | Handshake                        | Payload
//  ----------+----------------------------------+-------------------------------------
//  request   | start (in), busy (out)           | heading_angle, lateral_offset,
//            | taken when start & !busy         | reward_value, explore_draw, seed_acc,
//            |                                  | seed_dir, explore_acc, explore_dir
//  result    | done (out), one-cycle strobe     | chosen_acc, chosen_dir, angle_bin,
//            |                                  | offset_bin, explored
//  config    | APB psel/penable/pwrite, pready=1| paddr, pwdata, prdata
//
//  One request at a time. After acceptance: address prep, seed read, 70 scan
//  reads (one table read per cycle on the single RAM read port), drain,
//  read-modify-write of the previous entry (skipped on the very first step),
//  then the done cycle. A new request is taken only once the core is back in
//  idle after done.
//  After reset the table is zeroed by a sweep over all 13440 entries, one entry per
//  cycle; busy stays high meanwhile. Config writes are taken at any time.
//  The result is shown on done for one cycle; the receiver cannot stall it.

module tabular_q_learning_step_core
    import tqls_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,

    // config port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [CFG_ADDR_W-1:0]        paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,

    // request
    input  logic                         start,
    output logic                         busy,
    input  logic signed [ANGLE_W-1:0]    heading_angle,
    input  logic signed [OFFSET_W-1:0]   lateral_offset,
    input  logic signed [VALUE_W-1:0]    reward_value,
    input  logic [FRAC_W-1:0]            explore_draw,
    input  logic [ACC_W-1:0]             seed_acc,
    input  logic [DIR_W-1:0]             seed_dir,
    input  logic [ACC_W-1:0]             explore_acc,
    input  logic [DIR_W-1:0]             explore_dir,

    // result
    output logic                         done,
    output logic [ACC_W-1:0]             chosen_acc,
    output logic [DIR_W-1:0]             chosen_dir,
    output logic [BIN_W-1:0]             angle_bin,
    output logic [BIN_W-1:0]             offset_bin,
    output logic                         explored
);

    localparam int DPROD_W = VALUE_W + FRAC_W;        // discount * Q
    localparam int T_W     = VALUE_W + 2;             // reward + d - q
    localparam int LPROD_W = T_W + FRAC_W + 1;        // learn * t
    localparam int NV_W    = VALUE_W + 4;             // q + step, before saturation

    localparam logic signed [NV_W-1:0] SAT_HI = NV_W'(2147483647);
    localparam logic signed [NV_W-1:0] SAT_LO = -SAT_HI - NV_W'(1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [FRAC_W-1:0] learn_rate_reg;
    logic [FRAC_W-1:0] discount_factor_reg;
    logic [FRAC_W-1:0] explore_chance_reg;
    logic              cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_rate_reg      <= LEARN_RATE_RST;
            discount_factor_reg <= DISCOUNT_FACTOR_RST;
            explore_chance_reg  <= EXPLORE_CHANCE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_LEARN_RATE:      learn_rate_reg      <= pwdata[FRAC_W-1:0];
                REG_DISCOUNT_FACTOR: discount_factor_reg <= pwdata[FRAC_W-1:0];
                REG_EXPLORE_CHANCE:  explore_chance_reg  <= pwdata[FRAC_W-1:0];
                default:             ;    // unmapped slot, write dropped
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_LEARN_RATE:      prdata = 32'(learn_rate_reg);
            REG_DISCOUNT_FACTOR: prdata = 32'(discount_factor_reg);
            REG_EXPLORE_CHANCE:  prdata = 32'(explore_chance_reg);
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Quantizer on the request ports, latched at accept
    // ------------------------------------------------------------------
    logic [BIN_W-1:0] q_angle_bin;
    logic [BIN_W-1:0] q_offset_bin;

    tqls_quant u_quant (
        .heading_angle  (heading_angle),
        .lateral_offset (lateral_offset),
        .angle_bin      (q_angle_bin),
        .offset_bin     (q_offset_bin)
    );

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    logic   accept;

    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [ACC_W-1:0]  scan_acc_reg;
    logic [DIR_W-1:0]  scan_dir_reg;
    logic [ADDR_W-1:0] scan_addr_reg;
    logic              scan_last;

    logic              tag_valid_reg;
    logic              tag_seed_reg;
    logic [ACC_W-1:0]  tag_acc_reg;
    logic [DIR_W-1:0]  tag_dir_reg;

    logic              prev_valid_reg;
    logic [ADDR_W-1:0] prev_addr_reg;

    // request payload
    logic [BIN_W-1:0]         abin_reg;
    logic [BIN_W-1:0]         obin_reg;
    logic [ACC_W-1:0]         seed_acc_reg;
    logic [DIR_W-1:0]         seed_dir_reg;
    logic [ACC_W-1:0]         ex_acc_reg;
    logic [DIR_W-1:0]         ex_dir_reg;
    logic signed [VALUE_W-1:0] reward_reg;
    logic                     explored_reg;

    // scan result and update datapath
    logic signed [VALUE_W-1:0] best_reg;
    logic [ACC_W-1:0]          best_acc_reg;
    logic [DIR_W-1:0]          best_dir_reg;
    logic signed [VALUE_W-1:0] qo_reg;
    logic signed [DPROD_W-1:0] dprod_reg;
    logic signed [T_W-1:0]     t_reg;
    logic signed [LPROD_W-1:0] lprod_reg;
    logic signed [NV_W-1:0]    nv_sum;
    logic signed [VALUE_W-1:0] nv_sat;

    // RAM ports
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [VALUE_W-1:0]        ram_wdata;
    logic [ADDR_W-1:0]         ram_raddr;
    logic [VALUE_W-1:0]        ram_rdata;
    logic signed [VALUE_W-1:0] rd_value;

    // action offsets inside one state row
    logic [ACC_W-1:0]  seed_acc_mod;
    logic [DIR_W-1:0]  seed_dir_mod;
    logic [ACC_W-1:0]  ex_acc_mod;
    logic [DIR_W-1:0]  ex_dir_mod;
    logic [ACT_W-1:0]  seed_off;
    logic [ACT_W-1:0]  chosen_off;
    logic [ADDR_W-1:0] row_base;

    assign accept   = start & ~busy;
    assign rd_value = $signed(ram_rdata);

    // out-of-range indices wrap once (inputs are below twice the count)
    assign seed_acc_mod = (seed_acc >= ACC_W'(ACC_ACTIONS)) ? seed_acc - ACC_W'(ACC_ACTIONS)
                                                            : seed_acc;
    assign seed_dir_mod = (seed_dir >= DIR_W'(DIR_ACTIONS)) ? seed_dir - DIR_W'(DIR_ACTIONS)
                                                            : seed_dir;
    assign ex_acc_mod   = (explore_acc >= ACC_W'(ACC_ACTIONS))
                        ? explore_acc - ACC_W'(ACC_ACTIONS) : explore_acc;
    assign ex_dir_mod   = (explore_dir >= DIR_W'(DIR_ACTIONS))
                        ? explore_dir - DIR_W'(DIR_ACTIONS) : explore_dir;

    assign row_base   = ADDR_W'((ADDR_W'(abin_reg) * ADDR_W'(OFFSET_BINS) + ADDR_W'(obin_reg))
                        * ADDR_W'(ACTIONS));
    assign seed_off   = ACT_W'(seed_acc_reg) * ACT_W'(DIR_ACTIONS) + ACT_W'(seed_dir_reg);
    assign chosen_off = ACT_W'(chosen_acc) * ACT_W'(DIR_ACTIONS) + ACT_W'(chosen_dir);

    assign scan_last = (scan_acc_reg == ACC_W'(ACC_ACTIONS - 1))
                    && (scan_dir_reg == DIR_W'(DIR_ACTIONS - 1));

    // new value: floor(learn*t/2^16) added to old entry, saturated
    assign nv_sum = NV_W'(qo_reg) + NV_W'(lprod_reg >>> FRAC_W);
    always_comb
    begin
        if (nv_sum > SAT_HI)
        begin
            nv_sat = SAT_HI[VALUE_W-1:0];
        end
        else if (nv_sum < SAT_LO)
        begin
            nv_sat = SAT_LO[VALUE_W-1:0];
        end
        else
        begin
            nv_sat = nv_sum[VALUE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == ADDR_W'(TABLE_DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (start)     state_next = ST_PREP;
            ST_PREP:  state_next = ST_SEED;
            ST_SEED:  state_next = ST_SCAN;
            ST_SCAN:  if (scan_last) state_next = ST_DRAIN;
            ST_DRAIN: state_next = prev_valid_reg ? ST_MUL1 : ST_DONE;
            ST_MUL1:  state_next = ST_SUM;
            ST_SUM:   state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_WRITE;
            ST_WRITE: state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs of the sequencer: RAM control and handshake
    // ------------------------------------------------------------------
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = prev_addr_reg;
        ram_wdata = VALUE_W'(nv_sat);
        ram_raddr = scan_addr_reg;
        busy      = 1'b1;
        done      = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            ST_IDLE:  busy      = 1'b0;
            ST_SEED:  ram_raddr = base_reg + ADDR_W'(seed_off);
            ST_SCAN:  ram_raddr = scan_addr_reg;
            ST_DRAIN: ram_raddr = prev_addr_reg;    // old value of previous entry
            ST_WRITE: ram_we    = 1'b1;
            ST_DONE:  done      = 1'b1;
            default:  ;
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            scan_acc_reg   <= '0;
            scan_dir_reg   <= '0;
            tag_valid_reg  <= 1'b0;
            tag_seed_reg   <= 1'b0;
            prev_valid_reg <= 1'b0;
            prev_addr_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            tag_valid_reg <= (state_reg == ST_SEED) || (state_reg == ST_SCAN);
            tag_seed_reg  <= (state_reg == ST_SEED);

            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end

            if (state_reg == ST_SEED)
            begin
                scan_acc_reg <= '0;
                scan_dir_reg <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                if (scan_dir_reg == DIR_W'(DIR_ACTIONS - 1))
                begin
                    scan_dir_reg <= '0;
                    scan_acc_reg <= scan_acc_reg + ACC_W'(1);
                end
                else
                begin
                    scan_dir_reg <= scan_dir_reg + DIR_W'(1);
                end
            end

            if (state_reg == ST_DONE)
            begin
                prev_valid_reg <= 1'b1;
                prev_addr_reg  <= base_reg + ADDR_W'(chosen_off);
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            abin_reg     <= q_angle_bin;
            obin_reg     <= q_offset_bin;
            seed_acc_reg <= seed_acc_mod;
            seed_dir_reg <= seed_dir_mod;
            ex_acc_reg   <= ex_acc_mod;
            ex_dir_reg   <= ex_dir_mod;
            reward_reg   <= reward_value;
            explored_reg <= (explore_draw < explore_chance_reg);
        end

        if (state_reg == ST_PREP)
        begin
            base_reg <= row_base;
        end

        if (state_reg == ST_SEED)
        begin
            scan_addr_reg <= base_reg;
        end
        else if (state_reg == ST_SCAN)
        begin
            scan_addr_reg <= scan_addr_reg + ADDR_W'(1);
        end

        // tag is registered like the read data so that it lines up with the RAM data
        tag_acc_reg <= (state_reg == ST_SEED) ? seed_acc_reg : scan_acc_reg;
        tag_dir_reg <= (state_reg == ST_SEED) ? seed_dir_reg : scan_dir_reg;

        // seed loads the running best; scan moves only on strictly greater
        if (tag_valid_reg && (tag_seed_reg || (rd_value > best_reg)))
        begin
            best_reg     <= rd_value;
            best_acc_reg <= tag_acc_reg;
            best_dir_reg <= tag_dir_reg;
        end

        if (state_reg == ST_MUL1)
        begin
            qo_reg    <= rd_value;
            dprod_reg <= $signed({1'b0, discount_factor_reg}) * best_reg;
        end

        if (state_reg == ST_SUM)
        begin
            t_reg <= T_W'(reward_reg) + T_W'(dprod_reg >>> FRAC_W) - T_W'(qo_reg);
        end

        if (state_reg == ST_MUL2)
        begin
            lprod_reg <= $signed({1'b0, learn_rate_reg}) * t_reg;
        end
    end

    // ------------------------------------------------------------------
    // Value table
    // ------------------------------------------------------------------
    tqls_ram #(
        .WIDTH  (VALUE_W),
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr  (ram_raddr),
        .rdata  (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Result
    // ------------------------------------------------------------------
    assign chosen_acc = explored_reg ? ex_acc_reg : best_acc_reg;
    assign chosen_dir = explored_reg ? ex_dir_reg : best_dir_reg;
    assign angle_bin  = abin_reg;
    assign offset_bin = obin_reg;
    assign explored   = explored_reg;

endmodule
